// ===== src/lfuc_pkg.sv =====
`timescale 1ns / 1ps

package lfuc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 31;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_INSERT,
        OP_EVICT
    } op_t;

    // sequencer -> datapath
    typedef struct packed {
        logic start;
        logic issue;
        logic scan;
        logic update;
        logic decide;
    } ctl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic addr_end;
        logic need_update;
    } sts_t;

endpackage

// ===== src/lfu_cache_lru_tiebreak_top.sv =====
`timescale 1ns / 1ps

// Channel   Beat marker                Payload           Notes
// request   start & !busy              req   (req_t)     get or put
// result    done (one cycle)           rsp   (rsp_t)     one per request, no back-pressure
// config    cfg_we                     cfg_wdata (5 bit) capacity, write while idle
//
// A request holds busy through a scan sweep alone (get miss, put at capacity zero) or
// through a scan and a write-back sweep (hit, insert, eviction): the entry memory is swept
// once to find the key, the victim and a free slot, and once more to write back
// ranks and counts. The result strobe is registered out of the decide state between them.
// Reset clears the valid bits and occupancy; the entry memory needs no clearing pass.
// The receiver takes every result beat as offered.

module lfu_cache_lru_tiebreak_top
    import lfuc_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             done,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    logic [CAP_W-1:0] capacity_reg;
    logic             done_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    ctl_t             ctl;
    sts_t             sts;

    // capacity register; values above ENTRIES are clipped in the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    lfuc_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    lfuc_dp #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .req      (req),
        .capacity (capacity_reg),
        .sts      (sts),
        .rsp      (rsp_next)
    );

    // result beat is registered out of the decide cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.decide;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.decide)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_done_while_busy_or_tail: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.decide |-> busy)
        else $error("decide outside a request");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request beat taken but block not busy");

endmodule

// ===== src/lfuc_ram.sv =====
`timescale 1ns / 1ps

module lfuc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/lfuc_fsm.sv =====
`timescale 1ns / 1ps

module lfuc_fsm
    import lfuc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output ctl_t ctl,
    output logic busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.addr_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = sts.need_update ? ST_UPDATE : ST_IDLE;
            end
            ST_UPDATE:
            begin
                if (sts.addr_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                ctl.start = start;
            end
            ST_SCAN:
            begin
                ctl.scan  = 1'b1;
                ctl.issue = !sts.addr_end;
            end
            ST_DECIDE:
            begin
                ctl.decide = 1'b1;
            end
            ST_UPDATE:
            begin
                ctl.update = 1'b1;
                ctl.issue  = !sts.addr_end;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

// ===== src/lfuc_dp.sv =====
`timescale 1ns / 1ps

module lfuc_dp
    import lfuc_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    input  req_t             req,
    input  logic [CAP_W-1:0] capacity,
    output sts_t             sts,
    output rsp_t             rsp
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // entry word: key | value | use count | recency rank
    localparam int CNT_LO = RANK_W;
    localparam int VAL_LO = CNT_LO + COUNT_BITS;
    localparam int KEY_LO = VAL_LO + VAL_W;
    localparam int WORD_W = KEY_LO + KEY_W;

    req_t                  req_reg;
    logic [CNT_W-1:0]      addr_reg;
    logic                  rd_pend_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [ENTRIES-1:0]    valid_reg;
    logic [CNT_W-1:0]      occupied_reg;
    op_t                   op_reg;

    // key match tracker
    logic                  m_hit_reg;
    logic [IDX_W-1:0]      m_idx_reg;
    logic [RANK_W-1:0]     m_rank_reg;
    logic [VAL_W-1:0]      m_value_reg;

    // victim tracker: lowest count, then oldest
    logic                  v_have_reg;
    logic [IDX_W-1:0]      v_idx_reg;
    logic [COUNT_BITS-1:0] v_count_reg;
    logic [RANK_W-1:0]     v_rank_reg;
    logic [KEY_W-1:0]      v_key_reg;

    // first free slot
    logic                  f_have_reg;
    logic [IDX_W-1:0]      f_idx_reg;

    logic [WORD_W-1:0]     rd_data;
    logic [WORD_W-1:0]     wr_data;
    logic                  ram_we;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;

    logic [KEY_W-1:0]      d_key;
    logic [VAL_W-1:0]      d_value;
    logic [COUNT_BITS-1:0] d_count;
    logic [RANK_W-1:0]     d_rank;
    logic                  d_valid;

    logic                  scan_beat;
    logic                  upd_beat;
    logic                  key_take;
    logic                  vic_take;
    logic                  free_take;

    logic [CMP_W-1:0]      cap_eff;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      ent_ext;
    logic [CMP_W-1:0]      occ_ext;
    op_t                   op_next;

    logic [IDX_W-1:0]      tgt_idx;
    logic                  is_tgt;
    logic                  bump;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [RANK_W-1:0]     rank_new;

    assign ram_re    = ctl.issue;
    assign ram_raddr = addr_reg[IDX_W-1:0];

    lfuc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rd_idx_reg),
        .wdata (wr_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign d_key   = rd_data[KEY_LO +: KEY_W];
    assign d_value = rd_data[VAL_LO +: VAL_W];
    assign d_count = rd_data[CNT_LO +: COUNT_BITS];
    assign d_rank  = rd_data[0 +: RANK_W];
    assign d_valid = valid_reg[rd_idx_reg];

    assign scan_beat = rd_pend_reg && ctl.scan;
    assign upd_beat  = rd_pend_reg && ctl.update;

    assign key_take  = d_valid && !m_hit_reg && (d_key == req_reg.key);
    assign vic_take  = d_valid && (!v_have_reg || (d_count < v_count_reg) ||
                       ((d_count == v_count_reg) && (d_rank > v_rank_reg)));
    assign free_take = !d_valid && !f_have_reg;

    // effective capacity is clipped to the table size
    assign cap_ext = CMP_W'(capacity);
    assign ent_ext = CMP_W'(ENTRIES);
    assign occ_ext = CMP_W'(occupied_reg);
    assign cap_eff = (cap_ext > ent_ext) ? ent_ext : cap_ext;

    always_comb
    begin
        op_next = OP_NONE;
        if (req_reg.req_type == REQ_GET)
        begin
            op_next = m_hit_reg ? OP_TOUCH : OP_NONE;
        end
        else if (cap_eff != '0)
        begin
            if (m_hit_reg)
            begin
                op_next = OP_TOUCH;
            end
            else if (occ_ext >= cap_eff)
            begin
                op_next = OP_EVICT;
            end
            else
            begin
                op_next = OP_INSERT;
            end
        end
    end

    always_comb
    begin
        rsp             = '0;
        rsp.hit         = (op_next == OP_TOUCH);
        rsp.read_value  = (op_next == OP_TOUCH && req_reg.req_type == REQ_GET) ?
                          m_value_reg : '0;
        rsp.evicted     = (op_next == OP_EVICT);
        rsp.evicted_key = (op_next == OP_EVICT) ? v_key_reg : '0;
    end

    assign sts.addr_end    = (addr_reg == CNT_W'(ENTRIES));
    assign sts.need_update = (op_next != OP_NONE);

    // write-back pass
    always_comb
    begin
        tgt_idx = f_idx_reg;
        bump    = 1'b1;
        case (op_reg)
            OP_TOUCH:
            begin
                tgt_idx = m_idx_reg;
                bump    = (d_rank < m_rank_reg);
            end
            OP_EVICT:
            begin
                tgt_idx = v_idx_reg;
                bump    = !(d_rank > v_rank_reg);
            end
            OP_INSERT:
            begin
                tgt_idx = f_idx_reg;
                bump    = 1'b1;
            end
            default:
            begin
                bump = 1'b0;
            end
        endcase
    end

    assign is_tgt   = (rd_idx_reg == tgt_idx);
    assign cnt_inc  = (d_count == '1) ? d_count : d_count + COUNT_BITS'(1);
    assign rank_new = bump ? d_rank + RANK_W'(1) : d_rank;
    assign ram_we   = upd_beat && (is_tgt || d_valid);

    always_comb
    begin
        wr_data = rd_data;
        if (is_tgt && op_reg == OP_TOUCH)
        begin
            wr_data[VAL_LO +: VAL_W]      = (req_reg.req_type == REQ_PUT) ?
                                            req_reg.value : d_value;
            wr_data[CNT_LO +: COUNT_BITS] = cnt_inc;
            wr_data[0 +: RANK_W]          = '0;
        end
        else if (is_tgt)
        begin
            wr_data[KEY_LO +: KEY_W]      = req_reg.key;
            wr_data[VAL_LO +: VAL_W]      = req_reg.value;
            wr_data[CNT_LO +: COUNT_BITS] = COUNT_BITS'(1);
            wr_data[0 +: RANK_W]          = '0;
        end
        else
        begin
            wr_data[0 +: RANK_W] = rank_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            req_reg <= req;
        end
        if (scan_beat && key_take)
        begin
            m_idx_reg   <= rd_idx_reg;
            m_rank_reg  <= d_rank;
            m_value_reg <= d_value;
        end
        if (scan_beat && vic_take)
        begin
            v_idx_reg   <= rd_idx_reg;
            v_count_reg <= d_count;
            v_rank_reg  <= d_rank;
            v_key_reg   <= d_key;
        end
        if (scan_beat && free_take)
        begin
            f_idx_reg <= rd_idx_reg;
        end
        if (ram_re)
        begin
            rd_idx_reg <= ram_raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            valid_reg    <= '0;
            occupied_reg <= '0;
            op_reg       <= OP_NONE;
            m_hit_reg    <= 1'b0;
            v_have_reg   <= 1'b0;
            f_have_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= ram_re;
            if (ctl.start || ctl.decide)
            begin
                addr_reg <= '0;
            end
            else if (ctl.issue)
            begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
            if (ctl.start)
            begin
                m_hit_reg  <= 1'b0;
                v_have_reg <= 1'b0;
                f_have_reg <= 1'b0;
            end
            else if (scan_beat)
            begin
                if (key_take)
                begin
                    m_hit_reg <= 1'b1;
                end
                if (vic_take)
                begin
                    v_have_reg <= 1'b1;
                end
                if (free_take)
                begin
                    f_have_reg <= 1'b1;
                end
            end
            if (ctl.decide)
            begin
                op_reg <= op_next;
                if (op_next == OP_INSERT)
                begin
                    valid_reg[f_idx_reg] <= 1'b1;
                    occupied_reg         <= occupied_reg + CNT_W'(1);
                end
            end
        end
    end

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occupied_reg))
        else $error("occupancy count out of step with valid bits");

    a_insert_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.decide && op_next == OP_INSERT) |-> (f_have_reg && !valid_reg[f_idx_reg]))
        else $error("insert without a free slot");

    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (rd_idx_reg != ram_raddr))
        else $error("write-back overlaps a read of the same entry");

    a_evict_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.decide && op_next == OP_EVICT) |-> v_have_reg)
        else $error("eviction without a victim");

endmodule

// ===== dv/lfu_cache_lru_tiebreak_top_tb.sv =====
`timescale 1ns / 1ps

module lfu_cache_lru_tiebreak_top_tb;
    import lfuc_pkg::*;

    localparam int N_SLOTS     = 16;
    // Narrow use counters: saturation and ties at the ceiling show up in normal traffic.
    localparam int CNT_W       = 4;
    localparam int RANK_W      = $clog2(N_SLOTS);
    localparam int POOL        = 40;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 165;
    // Margin past the longest busy stretch: a scan sweep, the decide state and a write-back sweep.
    localparam int TAIL_CYCLES = 2 * N_SLOTS + 8;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    req_t             req       = '0;
    logic             done;
    rsp_t             rsp;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    lfu_cache_lru_tiebreak_top #(
        .ENTRIES    (N_SLOTS),
        .COUNT_BITS (CNT_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the cache: per-slot key/value, use count and recency
    // rank (0 = most recent), plus occupancy and the capacity register.
    // ------------------------------------------------------------------
    logic              slot_valid [N_SLOTS];
    logic [KEY_W-1:0]  slot_key   [N_SLOTS];
    logic [VAL_W-1:0]  slot_value [N_SLOTS];
    logic [CNT_W-1:0]  slot_uses  [N_SLOTS];
    logic [RANK_W-1:0] slot_rank  [N_SLOTS];
    logic [4:0]        fill_level;
    logic [CAP_W-1:0]  cap_reg;

    req_t req_backlog [$];   // requests waiting for the driver
    rsp_t rsp_due     [$];   // predicted results, oldest first

    logic [KEY_W-1:0] key_pool [POOL];
    bit               no_gaps = 1'b0;

    int errors    = 0;
    int n_checked = 0;
    int n_gets    = 0;
    int n_puts    = 0;
    int n_hits    = 0;
    int n_evicts  = 0;
    int n_pinned  = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop well past the slowest legal run (about 2000 request beats).
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("[%0t] mismatch at result %0d, %s: got 0x%0h, want 0x%0h",
                 $time, n_checked, what, got, want);
    endtask

    // Hit on slot s: younger entries age by one, s becomes most recent, count
    // climbs until it pins at the ceiling.
    function automatic void touch_slot(int s);
        int i;
        for (i = 0; i < N_SLOTS; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s])
                slot_rank[i] = slot_rank[i] + 1'b1;
        slot_rank[s] = '0;
        if (slot_uses[s] != '1)
            slot_uses[s] = slot_uses[s] + 1'b1;
        else
            n_pinned++;
    endfunction

    // Apply one request to the shadow cache and return the result beat it owes.
    function automatic rsp_t cache_access(req_t r);
        rsp_t o;
        int   i;
        int   found;
        int   victim;
        int   slot;
        int   room;
        o = '0;
        room = int'(cap_reg);
        if (room > N_SLOTS)
            room = N_SLOTS;
        found = -1;
        for (i = 0; i < N_SLOTS; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == r.key)
                found = i;

        if (r.req_type == REQ_GET)
        begin
            n_gets++;
            if (found >= 0)
            begin
                o.hit        = 1'b1;
                o.read_value = slot_value[found];
                touch_slot(found);
            end
        end
        else
        begin
            n_puts++;
            // capacity zero: the put is dropped, even on a present key
            if (room != 0)
            begin
                if (found >= 0)
                begin
                    o.hit             = 1'b1;
                    slot_value[found] = r.value;
                    touch_slot(found);
                end
                else
                begin
                    slot = -1;
                    // full (or capacity lowered below occupancy): evict one
                    if (fill_level >= room && fill_level > 0)
                    begin
                        victim = -1;
                        for (i = 0; i < N_SLOTS; i++)
                            if (slot_valid[i] && (victim < 0 ||
                                slot_uses[i] < slot_uses[victim] ||
                                (slot_uses[i] == slot_uses[victim] &&
                                 slot_rank[i] > slot_rank[victim])))
                                victim = i;
                        o.evicted     = 1'b1;
                        o.evicted_key = slot_key[victim];
                        n_evicts++;
                        for (i = 0; i < N_SLOTS; i++)
                            if (slot_valid[i] && i != victim &&
                                slot_rank[i] > slot_rank[victim])
                                slot_rank[i] = slot_rank[i] - 1'b1;
                        slot_valid[victim] = 1'b0;
                        slot_uses[victim]  = '0;
                        slot_rank[victim]  = '0;
                        fill_level         = fill_level - 1'b1;
                        slot               = victim;
                    end
                    for (i = 0; i < N_SLOTS; i++)
                        if (slot < 0 && !slot_valid[i])
                            slot = i;
                    if (slot >= 0)
                    begin
                        for (i = 0; i < N_SLOTS; i++)
                            if (slot_valid[i])
                                slot_rank[i] = slot_rank[i] + 1'b1;
                        slot_valid[slot] = 1'b1;
                        slot_key[slot]   = r.key;
                        slot_value[slot] = r.value;
                        slot_uses[slot]  = CNT_W'(1);
                        slot_rank[slot]  = '0;
                        fill_level       = fill_level + 1'b1;
                    end
                end
            end
        end
        if (o.hit)
            n_hits++;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the backlog one beat at a time. A beat is taken at
    // an edge with start high and busy low; the prediction is made right
    // there from the request that was on the bus. About 23 percent of the
    // free cycles are left empty unless no_gaps is set. The request bus
    // carries junk while start is low.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            if (start && !busy)
                rsp_due.push_back(cache_access(req));
            if (!start || !busy)
            begin
                if (req_backlog.size() != 0 && (no_gaps || $urandom_range(99) >= 23))
                begin
                    start <= 1'b1;
                    req   <= req_backlog.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                    req   <= {$urandom, $urandom};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done cycle is a result beat; check it against the
    // oldest prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (rsp_due.size() == 0)
            begin
                flag_mismatch("result beat with nothing pending, key", rsp.evicted_key, 0);
            end
            else
            begin
                if (rsp.hit !== rsp_due[0].hit)
                    flag_mismatch("hit", 32'(rsp.hit), 32'(rsp_due[0].hit));
                if (rsp.read_value !== rsp_due[0].read_value)
                    flag_mismatch("read_value", 32'(rsp.read_value),
                                  32'(rsp_due[0].read_value));
                if (rsp.evicted !== rsp_due[0].evicted)
                    flag_mismatch("evicted", 32'(rsp.evicted), 32'(rsp_due[0].evicted));
                if (rsp.evicted_key !== rsp_due[0].evicted_key)
                    flag_mismatch("evicted_key", rsp.evicted_key, rsp_due[0].evicted_key);
                void'(rsp_due.pop_front());
            end
            n_checked++;
        end
    end

    function automatic req_t mk_req(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        req_t r;
        r.req_type = op;
        r.key      = k;
        r.value    = v;
        return r;
    endfunction

    // Random request: mostly keys from a pool a bit larger than the capacity,
    // a few hot keys that pin their counters, and some fresh keys.
    function automatic req_t pick_req(int span);
        req_t r;
        int   roll;
        roll       = $urandom_range(99);
        r.req_type = ($urandom_range(1) == 1) ? REQ_PUT : REQ_GET;
        if (roll < 15)
            r.key = key_pool[$urandom_range(2)];
        else if (roll < 90)
            r.key = key_pool[$urandom_range(span - 1)];
        else
            r.key = $urandom;
        case ($urandom_range(19))
            0:       r.value = '0;
            1:       r.value = '1;
            default: r.value = VAL_W'($urandom);
        endcase
        return r;
    endfunction

    // Hold off until the backlog is gone and every prediction has been matched,
    // then let the block finish its write-back sweep.
    task automatic settle();
        int waited;
        while (req_backlog.size() != 0 || start)
            @(posedge clk);
        waited = 0;
        while (rsp_due.size() != 0 && waited < 4 * N_SLOTS + 16)
        begin
            @(posedge clk);
            waited++;
        end
        while (rsp_due.size() != 0)
        begin
            flag_mismatch("missing result, evicted_key", 0, rsp_due[0].evicted_key);
            void'(rsp_due.pop_front());
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_reg    = v;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int               i;
        int               p;
        int               span;
        logic [CAP_W-1:0] cap;

        for (i = 0; i < N_SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_uses[i]  = '0;
            slot_rank[i]  = '0;
        end
        fill_level = '0;
        cap_reg    = CAP_RESET;
        for (i = 0; i < POOL; i++)
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at reset capacity: miss on empty, extreme keys and values,
        // update in place, fill to the brim, then two evictions (the tie among
        // count-1 entries goes to the least recently touched).
        req_backlog.push_back(mk_req(REQ_GET, key_pool[0], '1));
        req_backlog.push_back(mk_req(REQ_PUT, key_pool[0], '0));
        req_backlog.push_back(mk_req(REQ_PUT, key_pool[1], '1));
        req_backlog.push_back(mk_req(REQ_GET, key_pool[1], '0));
        req_backlog.push_back(mk_req(REQ_GET, key_pool[0], '1));
        req_backlog.push_back(mk_req(REQ_PUT, key_pool[0], 31'h2AAA_AAAA));
        for (i = 2; i < N_SLOTS; i++)
            req_backlog.push_back(mk_req(REQ_PUT, key_pool[i], VAL_W'($urandom)));
        req_backlog.push_back(mk_req(REQ_GET, key_pool[2], '0));
        req_backlog.push_back(mk_req(REQ_PUT, key_pool[N_SLOTS], 31'h5555_5555));
        req_backlog.push_back(mk_req(REQ_PUT, $urandom, VAL_W'($urandom)));
        req_backlog.push_back(mk_req(REQ_GET, key_pool[0], '0));
        settle();

        // Capacity zero: puts dropped even on a present key, gets still hit.
        set_capacity(0);
        req_backlog.push_back(mk_req(REQ_PUT, key_pool[0], 31'd5));
        req_backlog.push_back(mk_req(REQ_GET, key_pool[0], '0));
        req_backlog.push_back(mk_req(REQ_PUT, key_pool[POOL - 1], '1));
        settle();

        // Capacity well under occupancy: nothing flushed, one victim per insert.
        set_capacity(2);
        req_backlog.push_back(mk_req(REQ_PUT, key_pool[POOL - 1], '1));
        req_backlog.push_back(mk_req(REQ_GET, key_pool[POOL - 1], '0));
        settle();

        // Random phases over a sweep of capacities, including zero, one, the
        // top of the register (clamped to the slot count) and one random pick.
        // Each phase is split in two with a full drain in between.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       cap = 5'd16;
                1:       cap = 5'd0;
                2:       cap = 5'd1;
                3:       cap = 5'd31;
                4:       cap = 5'd2;
                5:       cap = 5'd16;
                6:       cap = 5'd3;
                7:       cap = 5'd17;
                8:       cap = 5'd5;
                9:       cap = 5'd8;
                default: cap = CAP_W'($urandom_range(31));
            endcase
            set_capacity(cap);
            span = (cap > N_SLOTS) ? N_SLOTS + 6 : cap + 6;
            if (cap == 0)
                span = 20;
            no_gaps = (p == 5);   // one long back-to-back stretch
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                req_backlog.push_back(pick_req(span));
                if (i == PHASE_ITEMS / 2)
                    settle();
            end
            settle();
        end
        no_gaps = 1'b0;

        $display("%0d gets, %0d puts: %0d hits, %0d evictions, %0d touches at count ceiling",
                 n_gets, n_puts, n_hits, n_evicts, n_pinned);
        $display("%0d result beats checked over %0d capacity settings",
                 n_checked, PHASES + 2);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
